// ===== hw/rtl/accel_step_detector_defines.svh =====
// Assertion macros shared by the step detector checker.
// No dependencies; each macro samples on clk, and ASD_ASSERT names rst directly.
`ifndef ACCEL_STEP_DETECTOR_DEFINES_SVH
`define ACCEL_STEP_DETECTOR_DEFINES_SVH

// Property checked outside reset only.
`define ASD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every edge, reset included.
`define ASD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/asd_pkg.sv =====
// Types, constants and codes for the accelerometer step detector.
// No dependencies; used by the controller, the datapath and the top level.
package asd_pkg;

  localparam int ACCEL_W       = 16;
  localparam int TIME_W        = 32;
  localparam int THRESH_W      = 15;
  localparam int REFRACT_W     = 16;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int STEP_COUNT_W  = 24;
  localparam int COUNT_WIDTH_DEF = 24;
  localparam int LEVEL_W       = 24;
  localparam int COEF_W        = 16;
  localparam int PROD_W        = LEVEL_W + COEF_W;
  localparam int SUMSQ_W       = 32;
  localparam int ROOT_W        = 16;
  localparam int MAG_SHIFT     = 8;
  localparam int DIFF_W        = LEVEL_W + 1;
  localparam int DELTA_W       = 16;
  localparam int CNT_W         = 4;

  localparam logic [COEF_W-1:0]   FAST_KEEP = 16'd55706;
  localparam logic [COEF_W-1:0]   FAST_TAKE = 16'd9830;
  localparam logic [COEF_W-1:0]   SLOW_KEEP = 16'd65208;
  localparam logic [COEF_W-1:0]   SLOW_TAKE = 16'd328;
  localparam logic [PROD_W:0]     ROUND_HALF = 41'd32768;
  localparam logic [LEVEL_W-1:0]  ONE_G_Q20 = 24'd1048576;
  localparam logic [SUMSQ_W-1:0]  ROOT_TOP_BIT = 32'h4000_0000;

  localparam logic [THRESH_W-1:0]  PEAK_RESET    = 15'd737;
  localparam logic [THRESH_W-1:0]  REARM_RESET   = 15'd246;
  localparam logic [REFRACT_W-1:0] REFRACT_RESET = 16'd280;

  localparam logic [CNT_W-1:0] SQUARE_LAST = 4'd2;
  localparam logic [CNT_W-1:0] ROOT_LAST   = 4'd15;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PEAK_THRESHOLD  = 2'd0,
    REG_REARM_THRESHOLD = 2'd1,
    REG_REFRACT_TIME    = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQUARE,
    OP_ROOT,
    OP_MUL_FAST,
    OP_ADD_FAST,
    OP_MUL_SLOW,
    OP_ADD_SLOW,
    OP_DETECT
  } dp_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_MUL_FAST,
    ST_ADD_FAST,
    ST_MUL_SLOW,
    ST_ADD_SLOW,
    ST_DETECT
  } state_t;

  typedef struct packed {
    dp_op_t op;
    axis_t  axis;
  } dp_cmd_t;

  typedef struct packed {
    logic clear;
  } dp_status_t;

endpackage

// ===== hw/rtl/asd_ctrl.sv =====
// Sequencing state machine for the step detector.
// Depends on asd_pkg; drives the datapath by command and reads its status.
module asd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  asd_pkg::dp_status_t stat,
  output asd_pkg::dp_cmd_t   ctl
);
  import asd_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid_next;
  logic             fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    fire       = 1'b0;
    ctl.op     = OP_NONE;
    ctl.axis   = AXIS_X;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cnt_next = '0;
        if (in_valid) begin
          ctl.op     = OP_LOAD;
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (stat.clear) begin
          state_next = ST_DETECT;
        end else begin
          ctl.op   = OP_SQUARE;
          ctl.axis = axis_t'(cnt[1:0]);
          if (cnt == SQUARE_LAST) begin
            cnt_next   = '0;
            state_next = ST_ROOT;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      ST_ROOT: begin
        ctl.op = OP_ROOT;
        if (cnt == ROOT_LAST) begin
          cnt_next   = '0;
          state_next = ST_MUL_FAST;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_MUL_FAST: begin
        ctl.op     = OP_MUL_FAST;
        state_next = ST_ADD_FAST;
      end
      ST_ADD_FAST: begin
        ctl.op     = OP_ADD_FAST;
        state_next = ST_MUL_SLOW;
      end
      ST_MUL_SLOW: begin
        ctl.op     = OP_MUL_SLOW;
        state_next = ST_ADD_SLOW;
      end
      ST_ADD_SLOW: begin
        ctl.op     = OP_ADD_SLOW;
        state_next = ST_DETECT;
      end
      ST_DETECT: begin
        if (!out_valid || out_ready) begin
          fire       = 1'b1;
          ctl.op     = OP_DETECT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    out_valid_next = (out_valid && !out_ready) || fire;
  end

endmodule

// ===== hw/rtl/asd_datapath.sv =====
// Datapath of the step detector: squares, iterative root, two low-pass filters,
// peak logic, step counter, configuration registers and the result register.
// Depends on asd_pkg; sequenced by asd_ctrl.
module asd_datapath #(
  parameter int COUNT_WIDTH = asd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  asd_pkg::dp_cmd_t                        ctl,
  output asd_pkg::dp_status_t                     stat,
  input  logic                                    cmd,
  input  logic signed [asd_pkg::ACCEL_W-1:0]      accel_x,
  input  logic signed [asd_pkg::ACCEL_W-1:0]      accel_y,
  input  logic signed [asd_pkg::ACCEL_W-1:0]      accel_z,
  input  logic [asd_pkg::TIME_W-1:0]              time_ms,
  input  logic                                    cfg_we,
  input  logic [asd_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [asd_pkg::CFG_DATA_W-1:0]          cfg_data,
  output logic [asd_pkg::STEP_COUNT_W-1:0]        step_count,
  output logic                                    new_step,
  output logic                                    peak_active,
  output logic signed [asd_pkg::DELTA_W-1:0]      level_delta
);
  import asd_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [THRESH_W-1:0]  peak_threshold;
  logic [THRESH_W-1:0]  rearm_threshold;
  logic [REFRACT_W-1:0] refract_time;

  logic                       clear_cmd;
  logic signed [ACCEL_W-1:0]  ax, ay, az;
  logic [TIME_W-1:0]          now;

  logic [SUMSQ_W-1:0] rem;
  logic [SUMSQ_W-1:0] root;
  logic [SUMSQ_W-1:0] bit_q;
  logic [SUMSQ_W-1:0] trial;
  logic signed [ACCEL_W-1:0]   sq_sel;
  logic signed [SUMSQ_W-1:0]   sq;

  logic [LEVEL_W-1:0] fast_level;
  logic [LEVEL_W-1:0] slow_baseline;
  logic [LEVEL_W-1:0] mag;
  logic [LEVEL_W-1:0] keep_a, take_a;
  logic [COEF_W-1:0]  keep_b, take_b;
  logic [PROD_W-1:0]  p_keep, p_take;
  logic [PROD_W:0]    filt_sum;

  logic                       in_peak, in_peak_next;
  logic [TIME_W-1:0]          last_step_time, last_step_time_next;
  logic [COUNT_WIDTH-1:0]     count_reg, count_reg_next;
  logic                       step_hit;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [DIFF_W-1:0]   peak_q20, rearm_q20;
  logic [TIME_W-1:0]          elapsed;
  logic signed [DIFF_W-MAG_SHIFT-1:0] diff_q12;
  logic signed [DELTA_W-1:0]  delta_sat;

  assign stat.clear = clear_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_threshold  <= PEAK_RESET;
      rearm_threshold <= REARM_RESET;
      refract_time    <= REFRACT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PEAK_THRESHOLD:  peak_threshold  <= cfg_data[THRESH_W-1:0];
        REG_REARM_THRESHOLD: rearm_threshold <= cfg_data[THRESH_W-1:0];
        REG_REFRACT_TIME:    refract_time    <= cfg_data[REFRACT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Squaring and the restoring square root.
  always_comb begin
    case (ctl.axis)
      AXIS_X:  sq_sel = ax;
      AXIS_Y:  sq_sel = ay;
      AXIS_Z:  sq_sel = az;
      default: sq_sel = ax;
    endcase
  end

  assign sq    = sq_sel * sq_sel;
  assign trial = root + bit_q;
  assign mag   = {root[ROOT_W-1:0], {MAG_SHIFT{1'b0}}};

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        clear_cmd <= cmd;
        ax        <= accel_x;
        ay        <= accel_y;
        az        <= accel_z;
        now       <= time_ms;
        rem       <= '0;
        root      <= '0;
        bit_q     <= ROOT_TOP_BIT;
      end
      OP_SQUARE: begin
        rem <= rem + $unsigned(sq);
      end
      OP_ROOT: begin
        if (rem >= trial) begin
          rem  <= rem - trial;
          root <= (root >> 1) + bit_q;
        end else begin
          root <= root >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      default: begin
      end
    endcase
  end

  // Filter multiplies, shared between the fast and the slow update.
  always_comb begin
    if (ctl.op == OP_MUL_SLOW) begin
      keep_a = slow_baseline;
      keep_b = SLOW_KEEP;
      take_a = fast_level;
      take_b = SLOW_TAKE;
    end else begin
      keep_a = fast_level;
      keep_b = FAST_KEEP;
      take_a = mag;
      take_b = FAST_TAKE;
    end
  end

  assign filt_sum = {1'b0, p_keep} + {1'b0, p_take} + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (ctl.op == OP_MUL_FAST || ctl.op == OP_MUL_SLOW) begin
      p_keep <= PROD_W'(keep_a) * PROD_W'(keep_b);
      p_take <= PROD_W'(take_a) * PROD_W'(take_b);
    end
  end

  // Peak detection, refractory time and the saturating counter.
  assign diff      = $signed({1'b0, fast_level}) - $signed({1'b0, slow_baseline});
  assign peak_q20  = $signed({2'b00, peak_threshold, {MAG_SHIFT{1'b0}}});
  assign rearm_q20 = $signed({2'b00, rearm_threshold, {MAG_SHIFT{1'b0}}});
  assign elapsed   = now - last_step_time;
  assign diff_q12  = diff[DIFF_W-1:MAG_SHIFT];

  always_comb begin
    in_peak_next        = in_peak;
    last_step_time_next = last_step_time;
    count_reg_next      = count_reg;
    step_hit            = 1'b0;
    if (clear_cmd) begin
      count_reg_next = '0;
    end else if (!in_peak && diff > peak_q20 && elapsed > TIME_W'(refract_time)) begin
      step_hit            = 1'b1;
      in_peak_next        = 1'b1;
      last_step_time_next = now;
      if (count_reg != COUNT_MAX) begin
        count_reg_next = count_reg + 1'b1;
      end
    end else if (in_peak && diff < rearm_q20) begin
      in_peak_next = 1'b0;
    end

    if (diff_q12 > $signed(DELTA_W'(16'sh7fff))) begin
      delta_sat = 16'sh7fff;
    end else if (diff_q12 < -$signed((DELTA_W + 1)'(17'sh08000))) begin
      delta_sat = 16'sh8000;
    end else begin
      delta_sat = diff_q12[DELTA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_level     <= ONE_G_Q20;
      slow_baseline  <= ONE_G_Q20;
      in_peak        <= 1'b0;
      last_step_time <= '0;
      count_reg      <= '0;
    end else begin
      case (ctl.op)
        OP_ADD_FAST: fast_level    <= filt_sum[PROD_W-1:COEF_W];
        OP_ADD_SLOW: slow_baseline <= filt_sum[PROD_W-1:COEF_W];
        OP_DETECT: begin
          in_peak        <= in_peak_next;
          last_step_time <= last_step_time_next;
          count_reg      <= count_reg_next;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_DETECT) begin
      step_count  <= STEP_COUNT_W'(count_reg_next);
      new_step    <= step_hit;
      peak_active <= in_peak_next;
      level_delta <= delta_sat;
    end
  end

endmodule

// ===== hw/rtl/accel_step_detector.sv =====
// Step detector top level. A sample beat is loaded, its axes squared and summed,
// its root taken in the sixteen passes of the square root unit, both filters
// updated and the result registered in the detect state; no new beat is taken
// until then. A clear beat goes from the square state to the detect state.
// Reset clears the filters to 1 g, the count, the peak flag and the last step
// time, and loads the register defaults; configuration writes are always taken.
module accel_step_detector #(
  parameter int COUNT_WIDTH = asd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 cmd,
  input  logic signed [asd_pkg::ACCEL_W-1:0]   accel_x,
  input  logic signed [asd_pkg::ACCEL_W-1:0]   accel_y,
  input  logic signed [asd_pkg::ACCEL_W-1:0]   accel_z,
  input  logic [asd_pkg::TIME_W-1:0]           time_ms,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [asd_pkg::STEP_COUNT_W-1:0]     step_count,
  output logic                                 new_step,
  output logic                                 peak_active,
  output logic signed [asd_pkg::DELTA_W-1:0]   level_delta,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [asd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [asd_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import asd_pkg::*;

  dp_cmd_t    ctl;
  dp_status_t stat;

  assign cfg_ready = 1'b1;

  asd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  asd_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .cmd         (cmd),
    .accel_x     (accel_x),
    .accel_y     (accel_y),
    .accel_z     (accel_z),
    .time_ms     (time_ms),
    .cfg_we      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .step_count  (step_count),
    .new_step    (new_step),
    .peak_active (peak_active),
    .level_delta (level_delta)
  );

endmodule

// ===== hw/rtl/asd_checker.sv =====
// Port-level checks for the step detector, bound to the top level.
// Depends on accel_step_detector_defines.svh and asd_pkg.
`include "accel_step_detector_defines.svh"

module asd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [asd_pkg::STEP_COUNT_W-1:0]  step_count,
  input logic                              new_step,
  input logic                              peak_active
);

  `ASD_ASSERT_ALWAYS(a_idle_after_reset, rst |=> !out_valid, "Result shown after reset.")

  `ASD_ASSERT(a_step_sets_peak, out_valid && new_step |-> peak_active, "Step counted without peak flag.")

  `ASD_ASSERT(a_one_beat_in_flight, in_valid && in_ready |=> !in_ready, "Second beat taken while busy.")

  `ASD_ASSERT(a_result_held, out_valid && !out_ready |=> out_valid && $stable(step_count), "Stalled result changed.")

endmodule

bind accel_step_detector asd_checker u_asd_checker (.*);
